/* src/assert_macros.svh */
// assertion macros used by the rtl datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`endif

`ifndef SYNTH
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

/* src/mavg_pkg.sv */
// types and constants of the moving average filter
package mavg_pkg;

    localparam int LEN_REG_W = 6;
    localparam int LEN_RESET = 8;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_DIV
    } t_state;

    typedef struct packed {
        logic accept;
        logic update;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_status;

endpackage

/* src/mavg_ram.sv */
// generic single write port ram with registered read
module mavg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/mavg_div.sv */
// bit-serial restoring divider, signed dividend, unsigned divisor, truncates toward zero
module mavg_div #(
    parameter int SUM_W = 21,
    parameter int LEN_W = 6,
    parameter int OUT_W = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [SUM_W-1:0] i_dividend,
    input  logic [LEN_W-1:0]        i_divisor,
    output logic                    o_busy,
    output logic                    o_done,
    output logic signed [OUT_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [LEN_W-1:0] r_rem;
    logic [SUM_W-1:0] r_quo;
    logic [LEN_W-1:0] r_div;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [LEN_W:0]   rem_sh;
    logic [LEN_W:0]   diff;
    logic             ge;
    logic [SUM_W-1:0] mag;
    logic [SUM_W-1:0] quo_signed;

    // magnitude of the dividend; the most negative sum still fits as unsigned
    assign mag = i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);

    assign rem_sh = {r_rem, r_quo[SUM_W-1]};
    assign ge     = rem_sh >= {1'b0, r_div};
    assign diff   = rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(SUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= mag;
            r_div <= i_divisor;
            r_neg <= i_dividend[SUM_W-1];
        end else if (r_busy) begin
            r_rem <= ge ? diff[LEN_W-1:0] : rem_sh[LEN_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], ge};
        end
    end

    assign quo_signed = r_neg ? SUM_W'(-r_quo) : r_quo;

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = OUT_W'(quo_signed);

endmodule

/* src/mavg_dp.sv */
// datapath: sample store, running sum, window length, divider and result register
`include "assert_macros.svh"

module mavg_dp import mavg_pkg::*; #(
    parameter int MAX_WINDOW   = 32,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_cmd                           i_cmd,
    output t_status                        o_status,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                           i_cfg_valid,
    input  logic [LEN_REG_W-1:0]           i_cfg_window_length,
    output logic                           o_average_valid,
    input  logic                           i_average_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_average
);

    localparam int WP_W   = $clog2(MAX_WINDOW);
    localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
    localparam int POS_W  = $clog2(2 * MAX_WINDOW);
    localparam int SUM_W  = SAMPLE_WIDTH + $clog2(MAX_WINDOW);
    localparam int EXT_W  = (LEN_W > LEN_REG_W) ? LEN_W : LEN_REG_W;
    localparam int LEN_RST = (LEN_RESET > MAX_WINDOW) ? MAX_WINDOW : LEN_RESET;

    logic [LEN_W-1:0]               r_len;
    logic [WP_W-1:0]                r_wp;
    logic signed [SUM_W-1:0]        r_sum;
    logic [MAX_WINDOW-1:0]          r_vld;
    logic                           r_old_vld;
    logic signed [SAMPLE_WIDTH-1:0] r_sample;
    logic                           r_avg_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_avg;

    logic [EXT_W-1:0]               cfg_ext;
    logic [LEN_W-1:0]               cfg_len;
    logic [POS_W-1:0]               pos_raw;
    logic [WP_W-1:0]                old_pos;
    logic [SAMPLE_WIDTH-1:0]        rd_data;
    logic signed [SUM_W-1:0]        old_ext;
    logic signed [SUM_W-1:0]        new_ext;
    logic signed [SUM_W-1:0]        n_sum;
    logic [WP_W-1:0]                n_wp;
    logic                           div_busy;
    logic                           div_done;
    logic signed [SAMPLE_WIDTH-1:0] quotient;

    // zero means one, anything above the store depth saturates
    assign cfg_ext = EXT_W'(i_cfg_window_length);
    always_comb begin
        priority if (cfg_ext == '0) begin
            cfg_len = LEN_W'(1);
        end else if (cfg_ext > EXT_W'(MAX_WINDOW)) begin
            cfg_len = LEN_W'(MAX_WINDOW);
        end else begin
            cfg_len = LEN_W'(cfg_ext);
        end
    end

    // position written window-length items ago, modulo the store depth
    assign pos_raw = POS_W'(r_wp) + POS_W'(MAX_WINDOW) - POS_W'(r_len);
    assign old_pos = (pos_raw >= POS_W'(MAX_WINDOW)) ? WP_W'(pos_raw - POS_W'(MAX_WINDOW))
                                                      : WP_W'(pos_raw);

    assign n_wp = (r_wp == WP_W'(MAX_WINDOW - 1)) ? '0 : r_wp + 1'b1;

    mavg_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (MAX_WINDOW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.update),
        .i_waddr (r_wp),
        .i_wdata (r_sample),
        .i_re    (i_cmd.accept),
        .i_raddr (old_pos),
        .o_rdata (rd_data)
    );

    // entries not written since the last clear read as zero
    assign old_ext = r_old_vld ? SUM_W'($signed(rd_data)) : '0;
    assign new_ext = SUM_W'(r_sample);
    assign n_sum   = r_sum - old_ext + new_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_W'(LEN_RST);
            r_wp  <= '0;
            r_sum <= '0;
            r_vld <= '0;
        end else if (i_cfg_valid) begin
            r_len <= cfg_len;
            r_wp  <= '0;
            r_sum <= '0;
            r_vld <= '0;
        end else if (i_cmd.update) begin
            r_wp        <= n_wp;
            r_sum       <= n_sum;
            r_vld[r_wp] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample  <= i_sample;
            r_old_vld <= r_vld[old_pos];
        end
    end

    mavg_div #(
        .SUM_W (SUM_W),
        .LEN_W (LEN_W),
        .OUT_W (SAMPLE_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.update),
        .i_dividend (n_sum),
        .i_divisor  (r_len),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_avg_valid <= 1'b1;
        end else if (i_average_ready) begin
            r_avg_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_avg <= quotient;
        end
    end

    assign o_status.div_done = div_done;
    assign o_status.out_free = !r_avg_valid || i_average_ready;

    assign o_average_valid = r_avg_valid;
    assign o_average       = r_avg;

    `ASSERT_CLK(a_len_range, i_clk, i_rst_n, (r_len != '0) && (r_len <= LEN_W'(MAX_WINDOW)), "window length out of range")
    `ASSERT_NEVER(a_start_busy, i_clk, i_rst_n, i_cmd.update && div_busy, "divider started while busy")
    `ASSERT_CLK(a_update_after_read, i_clk, i_rst_n, i_cmd.update |-> $past(i_cmd.accept), "update without store read")
    `ASSERT_CLK(a_load_done, i_clk, i_rst_n, i_cmd.load_out |-> (div_done && !div_busy), "result loaded before divide finished")

endmodule

/* src/mavg_ctrl.sv */
// controller: sequences read, update, divide and result load for one item
module mavg_ctrl import mavg_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_sample_valid,
    output logic    o_sample_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        unique case (r_state)
            S_IDLE: begin
                n_state = i_sample_valid ? S_UPDATE : S_IDLE;
            end
            S_UPDATE: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                // hold the quotient until the result register can take it
                n_state = (i_status.div_done && i_status.out_free) ? S_IDLE : S_DIV;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_sample_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_sample_ready = 1'b1;
                o_cmd.accept   = i_sample_valid;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            S_DIV: begin
                o_cmd.load_out = i_status.div_done && i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

/* src/moving_average_filter.sv */
// Moving average filter: each sample item yields one average item, the running sum of the
// newest window_length samples divided by the window length and truncated toward zero.
// Each item runs through the states idle (sample accepted, oldest entry read), update (sum
// and store written, divider started) and divide, where the result is loaded once the divider
// is done; no new sample is taken before that. SUM_W, SAMPLE_WIDTH + clog2(MAX_WINDOW), sets
// the divide length: the restoring divider produces one quotient bit per cycle. The next sample
// is taken in the cycle after the result is loaded, even if it has not yet been taken; while
// that result still waits, the following quotient is held and further samples stall.
// A window_length of zero acts as one and values above MAX_WINDOW saturate. Writing the
// register (accepted in any cycle, to be done only while idle) clears the store, the sum and
// the write pointer at once; per-entry valid bits stand in for a clearing pass.
module moving_average_filter import mavg_pkg::*; #(
    parameter int MAX_WINDOW   = 32,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_sample_valid,
    output logic                           o_sample_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic                           o_average_valid,
    input  logic                           i_average_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_average,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [LEN_REG_W-1:0]           i_cfg_window_length
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    mavg_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_status       (status),
        .o_cmd          (cmd)
    );

    mavg_dp #(
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_sample            (i_sample),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_window_length (i_cfg_window_length),
        .o_average_valid     (o_average_valid),
        .i_average_ready     (i_average_ready),
        .o_average           (o_average)
    );

endmodule

/* test/tb_moving_average_filter.sv */
// testbench for the moving average filter: directed table, then random samples checked against a predictor
module tb_moving_average_filter;
    import mavg_pkg::*;

    localparam int MAX_WINDOW = 32;
    localparam int SAMPLE_WIDTH = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 30;
    localparam int HOLD_CYCLES = 300;
    localparam int N_SEGMENTS = 9;
    localparam int ITEMS_PER_SEGMENT = 220;
    localparam int MAX_PRINTED = 40;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_CONFIG
    } row_kind_e;

    typedef struct {
        row_kind_e kind;
        sample_t   value;
        bit        typed;
        sample_t   want;
    } step_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_sample_valid = 1'b0;
    logic o_sample_ready;
    sample_t i_sample = '0;
    logic o_average_valid;
    logic i_average_ready = 1'b0;
    sample_t o_average;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [LEN_REG_W-1:0] i_cfg_window_length = '0;

    moving_average_filter #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_sample_valid     (i_sample_valid),
        .o_sample_ready     (o_sample_ready),
        .i_sample           (i_sample),
        .o_average_valid    (o_average_valid),
        .i_average_ready    (i_average_ready),
        .o_average          (o_average),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_window_length(i_cfg_window_length)
    );

    // directed rows; want is typed in only where it is obvious
    step_t directed_steps [0:23] = '{
        '{ROW_SAMPLE, 16'sh7FFF, 1'b1, 16'sd4095},
        '{ROW_SAMPLE, 16'sh8000, 1'b1, 16'sd0},
        '{ROW_SAMPLE, -16'sd1, 1'b0, 16'sd0},
        '{ROW_SAMPLE, 16'sd1, 1'b0, 16'sd0},
        '{ROW_CONFIG, 16'sd1, 1'b0, 16'sd0},
        '{ROW_SAMPLE, 16'sh8000, 1'b1, 16'sh8000},
        '{ROW_SAMPLE, 16'sh7FFF, 1'b1, 16'sh7FFF},
        '{ROW_CONFIG, 16'sd0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, -16'sd12345, 1'b1, -16'sd12345},
        '{ROW_SAMPLE, 16'sd5, 1'b1, 16'sd5},
        '{ROW_CONFIG, 16'sd63, 1'b0, 16'sd0},
        '{ROW_SAMPLE, 16'sh8000, 1'b1, -16'sd1024},
        '{ROW_SAMPLE, 16'sh7FFF, 1'b1, 16'sd0},
        '{ROW_CONFIG, 16'sd32, 1'b0, 16'sd0},
        '{ROW_SAMPLE, 16'sh7FFF, 1'b1, 16'sd1023},
        '{ROW_CONFIG, 16'sd33, 1'b0, 16'sd0},
        '{ROW_SAMPLE, 16'sh8000, 1'b1, -16'sd1024},
        '{ROW_CONFIG, 16'sd2, 1'b0, 16'sd0},
        '{ROW_SAMPLE, -16'sd3, 1'b1, -16'sd1},
        '{ROW_SAMPLE, 16'sd0, 1'b1, -16'sd1},
        '{ROW_SAMPLE, 16'sd0, 1'b1, 16'sd0},
        '{ROW_CONFIG, 16'sd31, 1'b0, 16'sd0},
        '{ROW_SAMPLE, 16'sh5555, 1'b0, 16'sd0},
        '{ROW_SAMPLE, 16'shAAAA, 1'b0, 16'sd0}
    };

    logic [LEN_REG_W-1:0] segment_lengths [0:N_SEGMENTS-2] = '{
        6'd5, 6'd32, 6'd1, 6'd63, 6'd17, 6'd0, 6'd2, 6'd33
    };

    // predictor state
    sample_t window_store [MAX_WINDOW];
    int unsigned store_pos;
    int window_sum;
    logic [LEN_REG_W-1:0] window_len_reg;

    sample_t pending_averages [$];
    int error_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int holds_requested = 0;
    int holds_served = 0;
    int hold_left = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_error(input string msg);
        if (error_count < MAX_PRINTED) begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
        error_count++;
    endtask

    function automatic void clear_window_state();
        foreach (window_store[k]) window_store[k] = '0;
        store_pos = 0;
        window_sum = 0;
    endfunction

    // running sum over the newest samples, divided with truncation toward zero
    function automatic sample_t predict_average(input sample_t s);
        int unsigned eff;
        int unsigned oldest;
        int quotient;
        if (window_len_reg == 0) eff = 1;
        else if (window_len_reg > MAX_WINDOW) eff = MAX_WINDOW;
        else eff = window_len_reg;
        oldest = (store_pos + MAX_WINDOW - eff) % MAX_WINDOW;
        window_sum = window_sum - int'(window_store[oldest]) + int'(s);
        window_store[store_pos] = s;
        store_pos = (store_pos + 1) % MAX_WINDOW;
        quotient = window_sum / int'(eff);
        return sample_t'(quotient);
    endfunction

    function automatic sample_t random_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 12) begin
            case ($urandom_range(3))
                0: return 16'sh8000;
                1: return 16'sh7FFF;
                2: return 16'sd0;
                default: return -16'sd1;
            endcase
        end else if (pick < 27) begin
            return sample_t'(int'($urandom_range(200)) - 100);
        end
        return sample_t'($urandom);
    endfunction

    task automatic send_sample(input sample_t s, input bit typed, input sample_t want);
        sample_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_sample_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_sample_valid <= 1'b1;
        i_sample <= s;
        @(posedge i_clk);
        while (!o_sample_ready) @(posedge i_clk);
        predicted = predict_average(s);
        pending_averages.push_back(typed ? want : predicted);
    endtask

    task automatic wait_until_drained();
        i_sample_valid <= 1'b0;
        while (pending_averages.size() != 0) @(posedge i_clk);
    endtask

    // only written with nothing in flight
    task automatic write_window_length(input logic [LEN_REG_W-1:0] len);
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_window_length <= len;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        window_len_reg = len;
        clear_window_state();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_average_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_average_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_served != holds_requested) begin
            i_average_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end else begin
            i_average_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        sample_t want;
        if (i_rst_n && o_average_valid && i_average_ready) begin
            if (pending_averages.size() == 0) begin
                report_error($sformatf("unexpected average %0d", o_average));
            end else begin
                want = pending_averages.pop_front();
                if (o_average !== want) begin
                    report_error($sformatf("average got %0d want %0d", o_average, want));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        window_len_reg = LEN_REG_W'(LEN_RESET);
        clear_window_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 35;
        recv_idle_pct = 51;
        foreach (directed_steps[k]) begin
            if (directed_steps[k].kind == ROW_CONFIG) begin
                write_window_length(directed_steps[k].value[LEN_REG_W-1:0]);
            end else begin
                send_sample(directed_steps[k].value, directed_steps[k].typed,
                            directed_steps[k].want);
            end
        end

        for (int seg = 0; seg < N_SEGMENTS; seg++) begin
            if (seg < 3) begin
                send_idle_pct = 35;
                recv_idle_pct = 51;
            end else if (seg < 6) begin
                send_idle_pct = 51;
                recv_idle_pct = 35;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (seg == N_SEGMENTS - 1) begin
                write_window_length(LEN_REG_W'($urandom_range(1, 63)));
            end else begin
                write_window_length(segment_lengths[seg]);
            end
            for (int n = 0; n < ITEMS_PER_SEGMENT; n++) begin
                // long receiver stall while samples keep coming
                if (n == 40 && (seg == 0 || seg == 6)) holds_requested <= holds_requested + 1;
                if (n == 110 && seg == 3) wait_until_drained();
                send_sample(random_sample(), 1'b0, '0);
            end
        end

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/mavg_pkg.sv
src/mavg_ram.sv
src/mavg_div.sv
src/mavg_dp.sv
src/mavg_ctrl.sv
src/moving_average_filter.sv
test/tb_moving_average_filter.sv
